// ===== design/cslr_pkg.sv =====
`default_nettype none

package cslr_pkg;

	localparam int unsigned ACCESS_W   = 16;
	localparam int unsigned PERIOD_W   = 16;
	localparam int unsigned WAY_USED_W = 3;
	localparam int unsigned CFG_IDX_W  = 1;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'hFFFF;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY_SELECT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AGING_PERIOD  = 1'd1;

	localparam logic POLICY_LRU = 1'b0;
	localparam logic POLICY_LFU = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_UPDATE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic in_valid;
		logic hit_now;
		logic scan_last;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic in_ready;
		logic scan_en;
		logic pick_en;
		logic upd_en;
		logic load_out;
	} ctrl_t;

endpackage

`default_nettype wire

// ===== design/cslr_seq.sv =====
`default_nettype none

module cslr_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cslr_pkg::status_t sts,
	output cslr_pkg::ctrl_t      ctl
);

	cslr_pkg::state_t state_q;
	cslr_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cslr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			cslr_pkg::ST_IDLE: begin
				if (sts.in_valid) begin
					state_nxt = cslr_pkg::ST_SCAN;
				end
			end
			cslr_pkg::ST_SCAN: begin
				if (sts.hit_now || sts.scan_last) begin
					state_nxt = cslr_pkg::ST_PICK;
				end
			end
			cslr_pkg::ST_PICK: begin
				state_nxt = cslr_pkg::ST_UPDATE;
			end
			cslr_pkg::ST_UPDATE: begin
				state_nxt = cslr_pkg::ST_RESULT;
			end
			cslr_pkg::ST_RESULT: begin
				if (sts.out_free) begin
					state_nxt = cslr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = cslr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl          = '0;
		ctl.in_ready = (state_q == cslr_pkg::ST_IDLE);
		ctl.scan_en  = (state_q == cslr_pkg::ST_SCAN);
		ctl.pick_en  = (state_q == cslr_pkg::ST_PICK);
		ctl.upd_en   = (state_q == cslr_pkg::ST_UPDATE);
		ctl.load_out = (state_q == cslr_pkg::ST_RESULT) && sts.out_free;
	end

endmodule

`default_nettype wire

// ===== design/cache_set_lru_lfu_replacement_unit.sv =====
// One cache set of WAYS lines with LRU or LFU victim choice. A request is taken when in_ready
// is high; the recency list is then walked from the MRU end, one way per cycle through a single
// tag comparator and use-count comparator, stopping at a hit. Each request then passes the pick,
// update and result states, and the next is taken only once the unit is back in idle. The result
// is held in an output register, so a new request is taken while the previous result waits. Use
// counts and the access counter are cleared when a request is accepted while the counter equals
// aging_period. Configuration is taken every cycle.
`default_nettype none

module cache_set_lru_lfu_replacement_unit #(
	parameter int unsigned WAYS       = 8,
	parameter int unsigned TAG_BITS   = 20,
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [cslr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [cslr_pkg::PERIOD_W-1:0]      cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [TAG_BITS-1:0]                req_tag,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    hit,
	output logic [cslr_pkg::WAY_USED_W-1:0]         way_used
);

	localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic [WAY_W-1:0]      LAST_POS  = WAY_W'(WAYS - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	cslr_pkg::status_t sts;
	cslr_pkg::ctrl_t   ctl;

	logic                           policy_q;
	logic [cslr_pkg::PERIOD_W-1:0]  aging_q;

	logic [TAG_BITS-1:0]   tag_q   [WAYS];
	logic [WAYS-1:0]       valid_q;
	logic [COUNT_BITS-1:0] cnt_q   [WAYS];
	logic [WAY_W-1:0]      order_q [WAYS];
	logic [cslr_pkg::ACCESS_W-1:0] total_q;

	logic [TAG_BITS-1:0]   req_q;
	logic [WAY_W-1:0]      pos_q;
	logic                  hit_q;
	logic [WAY_W-1:0]      hit_pos_q;
	logic                  have_free_q;
	logic [WAY_W-1:0]      free_pos_q;
	logic                  have_lfu_q;
	logic [WAY_W-1:0]      lfu_pos_q;
	logic [COUNT_BITS-1:0] lfu_cnt_q;
	logic [WAY_W-1:0]      sel_q;
	logic [WAY_W-1:0]      vic_way_q;

	logic                  out_valid_q;
	logic                  out_hit_q;
	logic [cslr_pkg::WAY_USED_W-1:0] out_way_q;

	logic                  in_fire;
	logic [WAY_W-1:0]      scan_way;
	logic                  scan_valid;
	logic                  hit_now;
	logic [WAY_W-1:0]      sel_nxt;
	logic                  age_clear;

	assign cfg_ready = 1'b1;
	assign in_ready  = ctl.in_ready;
	assign in_fire   = in_valid && ctl.in_ready;
	assign out_valid = out_valid_q;
	assign hit       = out_hit_q;
	assign way_used  = out_way_q;

	assign scan_way   = order_q[pos_q];
	assign scan_valid = valid_q[scan_way];
	assign hit_now    = scan_valid && (tag_q[scan_way] == req_q);
	assign age_clear  = in_fire && (total_q == aging_q);

	assign sts.in_valid  = in_valid;
	assign sts.hit_now   = hit_now;
	assign sts.scan_last = (pos_q == LAST_POS);
	assign sts.out_free  = !out_valid_q || out_ready;

	cslr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= cslr_pkg::POLICY_LRU;
			aging_q  <= cslr_pkg::PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == cslr_pkg::REG_POLICY_SELECT) begin
				policy_q <= cfg_data[0];
			end else if (cfg_index == cslr_pkg::REG_AGING_PERIOD) begin
				aging_q <= cfg_data;
			end
		end
	end

	// scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			hit_q       <= 1'b0;
			have_free_q <= 1'b0;
			have_lfu_q  <= 1'b0;
		end else if (in_fire) begin
			pos_q       <= '0;
			hit_q       <= 1'b0;
			have_free_q <= 1'b0;
			have_lfu_q  <= 1'b0;
		end else if (ctl.scan_en) begin
			if (hit_now) begin
				hit_q <= 1'b1;
			end else if (!scan_valid) begin
				have_free_q <= 1'b1;
			end else if (!have_lfu_q || (cnt_q[scan_way] <= lfu_cnt_q)) begin
				have_lfu_q <= 1'b1;
			end
			if (!sts.scan_last) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q <= req_tag;
		end
		if (ctl.scan_en) begin
			if (hit_now) begin
				hit_pos_q <= pos_q;
			end else if (!scan_valid) begin
				free_pos_q <= pos_q;
			end else if (!have_lfu_q || (cnt_q[scan_way] <= lfu_cnt_q)) begin
				lfu_pos_q <= pos_q;
				lfu_cnt_q <= cnt_q[scan_way];
			end
		end
		if (ctl.pick_en) begin
			sel_q     <= sel_nxt;
			vic_way_q <= order_q[sel_nxt];
		end
		if (ctl.upd_en && !hit_q) begin
			tag_q[vic_way_q] <= req_q;
		end
	end

	always_comb begin
		priority if (hit_q) begin
			sel_nxt = hit_pos_q;
		end else if (have_free_q) begin
			sel_nxt = free_pos_q;
		end else if ((policy_q == cslr_pkg::POLICY_LFU) && have_lfu_q) begin
			sel_nxt = lfu_pos_q;
		end else begin
			sel_nxt = LAST_POS;
		end
	end

	// line state, recency list and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
			for (int w = 0; w < WAYS; w++) begin
				cnt_q[w]   <= '0;
				order_q[w] <= WAY_W'(w);
			end
		end else if (age_clear) begin
			total_q <= '0;
			for (int w = 0; w < WAYS; w++) begin
				cnt_q[w] <= '0;
			end
		end else if (ctl.upd_en) begin
			valid_q[vic_way_q] <= 1'b1;
			total_q            <= total_q + 1'b1;
			if (!hit_q) begin
				cnt_q[vic_way_q] <= COUNT_BITS'(1);
			end else if (cnt_q[vic_way_q] != COUNT_MAX) begin
				cnt_q[vic_way_q] <= cnt_q[vic_way_q] + 1'b1;
			end
			for (int p = 1; p < WAYS; p++) begin
				if (WAY_W'(p) <= sel_q) begin
					order_q[p] <= order_q[p-1];
				end
			end
			order_q[0] <= vic_way_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_hit_q <= hit_q;
			out_way_q <= cslr_pkg::WAY_USED_W'(vic_way_q);
		end
	end

endmodule

`default_nettype wire

// ===== design/cslr_checker.sv =====
`default_nettype none

module cslr_checker #(
	parameter int unsigned WAYS     = 8,
	parameter int unsigned TAG_BITS = 20
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           cfg_valid,
	input wire logic                           cfg_ready,
	input wire logic [cslr_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [cslr_pkg::PERIOD_W-1:0]  cfg_data,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic [TAG_BITS-1:0]            req_tag,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic                           hit,
	input wire logic [cslr_pkg::WAY_USED_W-1:0] way_used
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(way_used))
		else $error("result changed while stalled");

	// waiting request keeps its tag
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(req_tag))
		else $error("request changed while waiting");

	// at least scan and pick cycles pass before another request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("request taken while busy");

	a_way_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (WAYS >= 8) || (way_used < WAYS))
		else $error("way out of range");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready || (cfg_index != cslr_pkg::REG_POLICY_SELECT) || cfg_data[0])
		else $error("config write refused");

endmodule

bind cache_set_lru_lfu_replacement_unit cslr_checker #(
	.WAYS     (WAYS),
	.TAG_BITS (TAG_BITS)
) u_cslr_checker (.*);

`default_nettype wire

// ===== bench/tb_cache_set_lru_lfu_replacement_unit.sv =====
`timescale 1ns / 1ps

module tb_cache_set_lru_lfu_replacement_unit;

	localparam int unsigned WAYS       = 8;
	localparam int unsigned TAG_W      = 20;
	localparam int unsigned COUNT_W    = 16;
	localparam int unsigned STUCK_MAX  = 3000;
	localparam int unsigned HOLD_LEN   = 300;

	typedef struct packed {
		logic                            hit;
		logic [cslr_pkg::WAY_USED_W-1:0] way;
	} access_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [cslr_pkg::CFG_IDX_W-1:0] cfg_index = cslr_pkg::REG_POLICY_SELECT;
	logic [cslr_pkg::PERIOD_W-1:0]  cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [TAG_W-1:0]               req_tag = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic                           hit;
	logic [cslr_pkg::WAY_USED_W-1:0] way_used;

	// shadow of the set
	logic [TAG_W-1:0]               line_tags [WAYS];
	logic                           line_valid [WAYS];
	logic [COUNT_W-1:0]             use_cnt [WAYS];
	logic [2:0]                     mru_order [WAYS];
	logic [cslr_pkg::ACCESS_W-1:0]  access_total;
	logic                           pol_sel;
	logic [cslr_pkg::PERIOD_W-1:0]  aging_limit;

	access_result_t       access_results [$];
	int unsigned          mismatch_count = 0;
	int unsigned          stuck_cycles = 0;

	logic [TAG_W-1:0]     tag_pool [16];
	int unsigned          pool_n = 8;

	bit                   tx_idling = 1'b1;
	int unsigned          tx_burst_left = 4;

	int unsigned          rx_mode = 0;
	int unsigned          rx_mode_left = 0;
	int unsigned          rx_hold_count = 0;
	int unsigned          rx_hold_seen = 0;
	int unsigned          rx_hold_left = 0;

	cache_set_lru_lfu_replacement_unit #(
		.WAYS(WAYS),
		.TAG_BITS(TAG_W),
		.COUNT_BITS(COUNT_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_tag(req_tag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.way_used(way_used)
	);

	always #1 clk = ~clk;

	function automatic void reset_shadow();
		for (int w = 0; w < WAYS; w++) begin
			line_tags[w] = '0;
			line_valid[w] = 1'b0;
			use_cnt[w] = '0;
			mru_order[w] = 3'(w);
		end
		access_total = '0;
		pol_sel = cslr_pkg::POLICY_LRU;
		aging_limit = cslr_pkg::PERIOD_RESET;
	endfunction

	function automatic access_result_t predict_access(input logic [TAG_W-1:0] tag);
		access_result_t res;
		bit found, have_free, have_lfu;
		int hit_pos, free_pos, lfu_pos, sel;
		logic [2:0] w;
		found = 0;
		have_free = 0;
		have_lfu = 0;
		hit_pos = 0;
		free_pos = 0;
		lfu_pos = 0;
		if (access_total == aging_limit) begin
			access_total = '0;
			for (int i = 0; i < WAYS; i++)
				use_cnt[i] = '0;
		end
		for (int p = 0; p < WAYS && !found; p++) begin
			w = mru_order[p];
			if (line_valid[w] && line_tags[w] == tag) begin
				found = 1;
				hit_pos = p;
			end else if (!line_valid[w]) begin
				have_free = 1;
				free_pos = p;
			end else if (!have_lfu || use_cnt[w] <= use_cnt[mru_order[lfu_pos]]) begin
				have_lfu = 1;
				lfu_pos = p;
			end
		end
		if (found)
			sel = hit_pos;
		else if (have_free)
			sel = free_pos;
		else if (pol_sel == cslr_pkg::POLICY_LFU && have_lfu)
			sel = lfu_pos;
		else
			sel = WAYS - 1;
		w = mru_order[sel];
		if (!found) begin
			line_tags[w] = tag;
			line_valid[w] = 1'b1;
			use_cnt[w] = '0;
		end
		for (int p = sel; p > 0; p--)
			mru_order[p] = mru_order[p - 1];
		mru_order[0] = w;
		if (use_cnt[w] != {COUNT_W{1'b1}})
			use_cnt[w] = use_cnt[w] + 1'b1;
		access_total = access_total + 1'b1;
		res.hit = found;
		res.way = w;
		return res;
	endfunction

	function automatic void new_pool(input int unsigned n);
		pool_n = n;
		for (int i = 0; i < 16; i++)
			tag_pool[i] = TAG_W'($urandom());
	endfunction

	function automatic logic [TAG_W-1:0] next_tag();
		if ($urandom_range(0, 99) < 85)
			return tag_pool[$urandom_range(0, pool_n - 1)];
		return TAG_W'($urandom());
	endfunction

	task automatic send_access(input logic [TAG_W-1:0] tag);
		int unsigned gap;
		gap = 0;
		in_valid <= 1'b1;
		req_tag <= tag;
		do @(posedge clk); while (in_ready !== 1'b1);
		access_results.push_back(predict_access(tag));
		if (tx_burst_left > 0)
			tx_burst_left--;
		if (tx_burst_left == 0) begin
			tx_burst_left = $urandom_range(1, 16);
			if (tx_idling)
				gap = $urandom_range(1, 10);
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic sender_stop();
		in_valid <= 1'b0;
	endtask

	task automatic wait_for_results();
		while (access_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic configure(input logic pol, input logic [cslr_pkg::PERIOD_W-1:0] period);
		wait_for_results();
		cfg_valid <= 1'b1;
		cfg_index <= cslr_pkg::REG_POLICY_SELECT;
		cfg_data <= {{(cslr_pkg::PERIOD_W-1){1'b0}}, pol};
		do @(posedge clk); while (cfg_ready !== 1'b1);
		pol_sel = pol;
		cfg_index <= cslr_pkg::REG_AGING_PERIOD;
		cfg_data <= period;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		aging_limit = period;
		cfg_valid <= 1'b0;
	endtask

	// one request at period == counter clears the counts, then the small period applies
	task automatic restart_aging(input logic pol, input logic [cslr_pkg::PERIOD_W-1:0] period);
		configure(pol, access_total);
		send_access(next_tag());
		sender_stop();
		configure(pol, period);
	endtask

	task automatic send_random(input int unsigned n);
		for (int i = 0; i < n; i++)
			send_access(next_tag());
		sender_stop();
	endtask

	task automatic test_directed_lru();
		logic [TAG_W-1:0] t [8];
		t = '{20'h00000, 20'hFFFFF, 20'hAAAAA, 20'h55555,
		      20'h0F0F0, 20'hF0F0F, 20'h12345, 20'hEDCBA};
		configure(cslr_pkg::POLICY_LRU, '0);
		tx_idling = 1'b0;
		for (int i = 0; i < 8; i++)
			send_access(t[i]);
		send_access(t[7]);
		send_access(t[0]);
		send_access(20'h00001);
		send_access(t[1]);
		sender_stop();
	endtask

	task automatic test_directed_lfu();
		configure(cslr_pkg::POLICY_LFU, cslr_pkg::PERIOD_RESET);
		tx_idling = 1'b1;
		repeat (3) send_access(20'h0F0F0);
		repeat (2) send_access(20'hF0F0F);
		send_access(20'h55555);
		send_access(20'h80000);
		send_access(20'h7FFFF);
		send_access(20'h80000);
		sender_stop();
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 7; ph++) begin
			new_pool($urandom_range(6, 14));
			tx_idling = (ph % 3) != 2;
			case (ph)
				0: restart_aging(cslr_pkg::POLICY_LFU,
				                 cslr_pkg::PERIOD_W'($urandom_range(3, 9)));
				1: configure(cslr_pkg::POLICY_LRU, cslr_pkg::PERIOD_RESET);
				2: configure(cslr_pkg::POLICY_LFU, '0);
				3: restart_aging(cslr_pkg::POLICY_LFU, cslr_pkg::PERIOD_W'(1));
				4: configure(cslr_pkg::POLICY_LRU,
				             cslr_pkg::PERIOD_W'($urandom_range(0, 65535)));
				5: restart_aging(cslr_pkg::POLICY_LRU,
				                 cslr_pkg::PERIOD_W'($urandom_range(2, 12)));
				default: restart_aging(cslr_pkg::POLICY_LFU,
				                       cslr_pkg::PERIOD_W'($urandom_range(10, 40)));
			endcase
			send_random(112);
		end
	endtask

	task automatic test_backpressure();
		new_pool(10);
		restart_aging(cslr_pkg::POLICY_LFU, cslr_pkg::PERIOD_W'(17));
		tx_idling = 1'b0;
		rx_hold_count++;
		send_random(50);
	endtask

	task automatic test_drain_pause();
		new_pool(9);
		configure(cslr_pkg::POLICY_LFU, cslr_pkg::PERIOD_RESET);
		tx_idling = 1'b1;
		send_random(40);
		wait_for_results();
		send_random(40);
	endtask

	// receiver pattern, with a long hold when asked
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_mode_left = $urandom_range(10, 80);
		end else begin
			rx_mode_left--;
		end
		if (rx_hold_seen != rx_hold_count) begin
			rx_hold_seen = rx_hold_count;
			rx_hold_left = HOLD_LEN;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		access_result_t exp_res;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (access_results.size() == 0) begin
				$display("%0t: result with no request pending: hit=%0b way=%0d",
				         $time, hit, way_used);
				mismatch_count++;
			end else begin
				exp_res = access_results.pop_front();
				if (hit !== exp_res.hit) begin
					$display("%0t: hit mismatch: expected %0b actual %0b",
					         $time, exp_res.hit, hit);
					mismatch_count++;
				end
				if (way_used !== exp_res.way) begin
					$display("%0t: way_used mismatch: expected %0d actual %0d",
					         $time, exp_res.way, way_used);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles == STUCK_MAX) begin
			$display("cache_set_lru_lfu_replacement_unit verification failed");
			$finish;
		end
	end

	initial begin
		reset_shadow();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_lru();
		test_directed_lfu();
		test_random_phases();
		test_backpressure();
		test_drain_pause();
		wait_for_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && access_results.size() == 0)
			$display("cache_set_lru_lfu_replacement_unit verification clean");
		else
			$display("cache_set_lru_lfu_replacement_unit verification failed");
		$finish;
	end

endmodule
